/* rtl/core/stmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmt_pkg
// Shared types and constants for the trace mute and taper block.
// ----------------------------------------------------------------------------
package stmt_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int TIME_W     = 16;
  localparam int IDX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int MID_DEPTH  = 4;
  localparam int OUT_DEPTH  = 4;
  localparam int DIV_STEPS  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_TIME       = 2'd0,
    CFG_SAMPLE_INTERVAL   = 2'd1,
    CFG_SAMPLES_PER_TRACE = 2'd2,
    CFG_ZERO_DEAD_TRACES  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    F_RUN,
    F_MUL,
    F_CLAMP,
    F_DIV_TOP,
    F_DIV_BOT,
    F_EMIT
  } front_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] origin;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] count;
    logic              zero_dead;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       zero;
    logic                       use_top;
    logic [IDX_W-1:0]           idx_top;
    logic                       use_bot;
    logic [IDX_W-1:0]           idx_bot;
    logic [TIME_W-1:0]          top_out;
    logic [TIME_W-1:0]          bot_out;
    logic                       last;
  } mid_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [TIME_W-1:0]          top_out;
    logic [TIME_W-1:0]          bot_out;
    logic                       last;
  } out_item_t;

endpackage

/* rtl/core/seismic_trace_mute_taper_top.sv */
`timescale 1ns / 1ps
// Path: a sample inside a trace goes into the mid queue when accepted, then
//   through the back stages s0 and s1 into the result queue.
// Throughput: one sample per cycle within a trace while the mid queue has room.
//   The first sample of each trace holds the input while the shared divider
//   works out the top and then the bottom mute index.
// Reset: synchronous, active low; control registers return to their defaults.
// ----------------------------------------------------------------------------
// seismic_trace_mute_taper_top
// Top and bottom trace mute with sine-squared taper, queue interfaces on both
// sides and a configuration write port.
// ----------------------------------------------------------------------------
module seismic_trace_mute_taper_top
  import stmt_pkg::*;
#(
  parameter int TAPER_LEN = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       in_first_of_trace,
  input  logic [TIME_W-1:0]          in_top_mute_time,
  input  logic [TIME_W-1:0]          in_bottom_mute_time,
  input  logic                       in_trace_live,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [SAMPLE_W-1:0] out_muted_value,
  output logic [TIME_W-1:0]          out_top_mute_out,
  output logic [TIME_W-1:0]          out_bottom_mute_out,
  output logic                       out_last_of_trace,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [TIME_W-1:0]          cfg_data
);

  logic [TIME_W-1:0] origin_r;
  logic [TIME_W-1:0] interval_r;
  logic [TIME_W-1:0] count_r;
  logic              zero_dead_r;
  cfg_t              cfg;

  mid_item_t         mid_wr_item;
  mid_item_t         mid_rd_item;
  logic              mid_push;
  logic              mid_pop;
  logic              mid_full;
  logic              mid_empty;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  out_item_t         out_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r    <= 16'd0;
      interval_r  <= 16'd4;
      count_r     <= 16'd1000;
      zero_dead_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_ORIGIN_TIME:       origin_r    <= cfg_data;
        CFG_SAMPLE_INTERVAL:   interval_r  <= cfg_data;
        CFG_SAMPLES_PER_TRACE: count_r     <= cfg_data;
        CFG_ZERO_DEAD_TRACES:  zero_dead_r <= cfg_data[0];
        default:               origin_r    <= origin_r;
      endcase
    end
  end

  // zero count or interval acts as one
  always_comb begin
    cfg.origin    = origin_r;
    cfg.interval  = (interval_r == '0) ? TIME_W'(1) : interval_r;
    cfg.count     = (count_r == '0) ? TIME_W'(1) : count_r;
    cfg.zero_dead = zero_dead_r;
  end

  stmt_front #(
    .TAPER_LEN (TAPER_LEN)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_sample_value     (in_sample_value),
    .in_first_of_trace   (in_first_of_trace),
    .in_top_mute_time    (in_top_mute_time),
    .in_bottom_mute_time (in_bottom_mute_time),
    .in_trace_live       (in_trace_live),
    .mid_full            (mid_full),
    .mid_push            (mid_push),
    .mid_item            (mid_wr_item)
  );

  stmt_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_push),
    .wr_data (mid_wr_item),
    .rd_en   (mid_pop),
    .rd_data (mid_rd_item),
    .full    (mid_full),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  stmt_back #(
    .TAPER_LEN (TAPER_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_rd_item),
    .mid_pop   (mid_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  assign out_muted_value     = out_item.value;
  assign out_top_mute_out    = out_item.top_out;
  assign out_bottom_mute_out = out_item.bot_out;
  assign out_last_of_trace   = out_item.last;

  a_mid_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_full == (mid_count == MID_DEPTH)) && (mid_empty == (mid_count == 0)))
    else $error("mid queue flags disagree with its count");

endmodule

/* rtl/core/stmt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmt_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// 16 bits, so the upper dividend half is below the divisor.
// ----------------------------------------------------------------------------
module stmt_div
  import stmt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*TIME_W-1:0]   dividend,
  input  logic [TIME_W-1:0]     divisor,
  output logic                  done,
  output logic [TIME_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TIME_W-1:0]   rem_r;
  logic [TIME_W-1:0]   low_r;
  logic [TIME_W-1:0]   q_r;
  logic [TIME_W:0]     shifted;
  logic                fits;

  assign shifted = {rem_r, low_r[TIME_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[2*TIME_W-1:TIME_W];
      low_r <= dividend[TIME_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? TIME_W'(shifted - {1'b0, divisor}) : shifted[TIME_W-1:0];
      low_r <= {low_r[TIME_W-2:0], 1'b0};
      q_r   <= {q_r[TIME_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* rtl/core/stmt_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmt_fifo
// Small first-word-fall-through queue with an occupancy count.
// ----------------------------------------------------------------------------
module stmt_fifo
  import stmt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr;
  logic             do_rd;

  assign full  = count_r == CW'(DEPTH);
  assign empty = count_r == '0;
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign count   = count_r;

endmodule

/* rtl/core/stmt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmt_front
// Accepts samples, resolves the mute window of each trace and classifies
// every sample against it before handing it to the mid queue.
// ----------------------------------------------------------------------------
module stmt_front
  import stmt_pkg::*;
#(
  parameter int TAPER_LEN = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       in_first_of_trace,
  input  logic [TIME_W-1:0]          in_top_mute_time,
  input  logic [TIME_W-1:0]          in_bottom_mute_time,
  input  logic                       in_trace_live,
  input  logic                       mid_full,
  output logic                       mid_push,
  output mid_item_t                  mid_item
);

  localparam int        TW   = 2 * TIME_W;
  localparam logic [16:0] TL17 = 17'(TAPER_LEN);

  front_state_t               state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] val_r;
  logic [TIME_W-1:0]          top_in_r;
  logic [TIME_W-1:0]          bot_in_r;
  logic                       live_in_r;
  logic [TW-1:0]              tmax_r;
  logic [TIME_W-1:0]          top_out_r;
  logic [TIME_W-1:0]          bot_out_r;
  logic [TW-1:0]              bot_dvd_r;

  logic [TIME_W-1:0]          top_idx_r;
  logic [TIME_W-1:0]          bot_idx_r;
  logic                       live_r;
  logic [TIME_W-1:0]          j_r;

  logic                       accept;
  logic                       div_start;
  logic [TW-1:0]              div_dividend;
  logic                       div_done;
  logic [TIME_W-1:0]          div_q;

  logic [TW-1:0]              ot32;
  logic [TW-1:0]              top_lo, top_c;
  logic [TW-1:0]              bot_raw, bot_lo, bot_c;

  logic [TIME_W-1:0]          d_top;
  logic [TIME_W-1:0]          d_bot;
  logic                       zero;

  assign accept = in_push && !in_full;

  // clamp of the mute times to the trace span
  assign ot32    = TW'(cfg.origin);
  assign top_lo  = (TW'(top_in_r) < ot32) ? ot32 : TW'(top_in_r);
  assign top_c   = (top_lo > tmax_r) ? tmax_r : top_lo;
  assign bot_raw = (bot_in_r == '0) ? tmax_r : TW'(bot_in_r);
  assign bot_lo  = (bot_raw < ot32) ? ot32 : bot_raw;
  assign bot_c   = (bot_lo > tmax_r) ? tmax_r : bot_lo;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_RUN:     if (accept && in_first_of_trace) state_nxt = F_MUL;
      F_MUL:     state_nxt = F_CLAMP;
      F_CLAMP:   state_nxt = F_DIV_TOP;
      F_DIV_TOP: if (div_done) state_nxt = F_DIV_BOT;
      F_DIV_BOT: if (div_done) state_nxt = F_EMIT;
      F_EMIT:    if (!mid_full) state_nxt = F_RUN;
      default:   state_nxt = F_RUN;
    endcase
  end

  always_comb begin
    in_full      = 1'b1;
    mid_push     = 1'b0;
    div_start    = 1'b0;
    div_dividend = bot_dvd_r;
    unique case (state_r)
      F_RUN: begin
        in_full  = mid_full;
        mid_push = accept && !in_first_of_trace;
      end
      F_CLAMP: begin
        div_start    = 1'b1;
        div_dividend = top_c - ot32;
      end
      F_DIV_TOP: div_start = div_done;
      F_EMIT:    mid_push  = !mid_full;
      default: begin
        in_full = 1'b1;
      end
    endcase
  end

  // classify the sample against the current trace window
  assign zero  = (!live_r && cfg.zero_dead) || (j_r < top_idx_r) || (j_r >= bot_idx_r);
  assign d_top = j_r - top_idx_r;
  assign d_bot = bot_idx_r - 1'b1 - j_r;

  always_comb begin
    mid_item.value   = (state_r == F_EMIT) ? val_r : in_sample_value;
    mid_item.zero    = zero;
    mid_item.use_top = !zero && ({1'b0, d_top} < TL17);
    mid_item.idx_top = d_top[IDX_W-1:0];
    mid_item.use_bot = !zero && ({1'b0, d_bot} < TL17);
    mid_item.idx_bot = d_bot[IDX_W-1:0];
    mid_item.top_out = (state_r == F_EMIT) ? top_out_r : '0;
    mid_item.bot_out = (state_r == F_EMIT) ? bot_out_r : '0;
    mid_item.last    = j_r == (cfg.count - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_RUN;
      top_idx_r <= '0;
      bot_idx_r <= '0;
      live_r    <= 1'b1;
      j_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_DIV_TOP && div_done) begin
        top_idx_r <= div_q;
      end
      if (state_r == F_DIV_BOT && div_done) begin
        bot_idx_r <= div_q;
        live_r    <= live_in_r;
        j_r       <= '0;
      end else if (mid_push && j_r != '1) begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_RUN && accept) begin
      val_r     <= in_sample_value;
      top_in_r  <= in_top_mute_time;
      bot_in_r  <= in_bottom_mute_time;
      live_in_r <= in_trace_live;
    end
    if (state_r == F_MUL) begin
      tmax_r <= ot32 + TW'(cfg.count - 1'b1) * TW'(cfg.interval);
    end
    if (state_r == F_CLAMP) begin
      top_out_r <= top_c[TIME_W-1:0];
      bot_out_r <= (bot_c[TW-1:TIME_W] != '0) ? '1 : bot_c[TIME_W-1:0];
      bot_dvd_r <= bot_c - ot32;
    end
  end

  stmt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cfg.interval),
    .done     (div_done),
    .quotient (div_q)
  );

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> !mid_full)
    else $error("mid queue written while full");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == F_DIV_TOP || state_r == F_DIV_BOT))
    else $error("divider finished outside a divide state");

  a_window_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_DIV_BOT && div_done) |=> (state_r == F_EMIT && j_r == '0))
    else $error("trace window not armed before first sample");

endmodule

/* rtl/core/stmt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmt_back
// Applies the two sine-squared taper scalings with round half away from
// zero and queues the finished items.
// ----------------------------------------------------------------------------
module stmt_back
  import stmt_pkg::*;
#(
  parameter int TAPER_LEN = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mid_empty,
  input  mid_item_t mid_item,
  output logic      mid_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  localparam int TL_SZ = (TAPER_LEN > 0) ? TAPER_LEN : 1;
  localparam int TW    = (TL_SZ > 1) ? $clog2(TL_SZ) : 1;
  localparam int OCW   = $clog2(OUT_DEPTH + 1);
  localparam int SW    = OCW + 2;
  localparam int PW    = SAMPLE_W + 17;
  localparam logic [16:0] W_ONE = 17'h10000;

  function automatic logic [16:0] taper_weight(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [65:0] s;
    logic [63:0]        sq;
    logic [63:0]        w;
    x2 = (x * x) >> 30;
    t  = x;
    s  = $signed({2'b00, x});
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - $signed({2'b00, t});
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + $signed({2'b00, t});
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - $signed({2'b00, t});
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + $signed({2'b00, t});
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - $signed({2'b00, t});
    t  = ((t * x2) >> 30) / 64'd156;
    s  = s + $signed({2'b00, t});
    t  = ((t * x2) >> 30) / 64'd210;
    s  = s - $signed({2'b00, t});
    if (s[65]) begin
      s = '0;
    end
    sq = s[63:0] * s[63:0];
    w  = (sq + (64'd1 << 43)) >> 44;
    if (w > 64'd65536) begin
      w = 64'd65536;
    end
    return w[16:0];
  endfunction

  logic [16:0] weight_tbl [TL_SZ];

  for (genvar k = 0; k < TL_SZ; k++) begin : g_weight
    localparam logic [63:0] ANG = (64'd3373259427 * (k + 1)) / (2 * TL_SZ);
    assign weight_tbl[k] = taper_weight(ANG);
  end

  mid_item_t             s0_r;
  logic                  s0_v_r;

  logic                  s1_v_r;
  logic [SAMPLE_W-1:0]   s1_mag_r;
  logic                  s1_neg_r;
  logic                  s1_zero_r;
  logic                  s1_use_bot_r;
  logic [IDX_W-1:0]      s1_idx_bot_r;
  logic [TIME_W-1:0]     s1_top_r;
  logic [TIME_W-1:0]     s1_bot_r;
  logic                  s1_last_r;

  logic [SAMPLE_W-1:0]   mag0;
  logic [16:0]           w_top;
  logic [PW-1:0]         p_top;
  logic [16:0]           w_bot;
  logic [PW-1:0]         p_bot;
  logic [SAMPLE_W-1:0]   r_bot;

  out_item_t             wr_item;
  logic                  out_full;
  logic [OCW-1:0]        out_count;
  logic [SW-1:0]         pending;

  assign pending = SW'(out_count) + SW'(s0_v_r) + SW'(s1_v_r);
  assign mid_pop = !mid_empty && (pending < SW'(OUT_DEPTH));

  assign mag0  = s0_r.value[SAMPLE_W-1] ? SAMPLE_W'(-s0_r.value) : SAMPLE_W'(s0_r.value);
  assign w_top = s0_r.use_top ? weight_tbl[s0_r.idx_top[TW-1:0]] : W_ONE;
  assign p_top = PW'(mag0) * PW'(w_top) + PW'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      s0_v_r <= mid_pop;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s0_r <= mid_item;
    end
    s1_mag_r     <= p_top[SAMPLE_W+15:16];
    s1_neg_r     <= s0_r.value[SAMPLE_W-1];
    s1_zero_r    <= s0_r.zero;
    s1_use_bot_r <= s0_r.use_bot;
    s1_idx_bot_r <= s0_r.idx_bot;
    s1_top_r     <= s0_r.top_out;
    s1_bot_r     <= s0_r.bot_out;
    s1_last_r    <= s0_r.last;
  end

  assign w_bot = s1_use_bot_r ? weight_tbl[s1_idx_bot_r[TW-1:0]] : W_ONE;
  assign p_bot = PW'(s1_mag_r) * PW'(w_bot) + PW'(32768);
  assign r_bot = p_bot[SAMPLE_W+15:16];

  always_comb begin
    if (s1_zero_r) begin
      wr_item.value = '0;
    end else if (s1_neg_r) begin
      wr_item.value = $signed(-r_bot);
    end else begin
      wr_item.value = $signed(r_bot);
    end
    wr_item.top_out = s1_top_r;
    wr_item.bot_out = s1_bot_r;
    wr_item.last    = s1_last_r;
  end

  stmt_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_v_r),
    .wr_data (wr_item),
    .rd_en   (out_pop),
    .rd_data (out_item),
    .full    (out_full),
    .empty   (out_empty),
    .count   (out_count)
  );

  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !out_full)
    else $error("result queue written while full");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending <= SW'(OUT_DEPTH))
    else $error("more items in flight than result queue slots");

endmodule

/* bench/tb_seismic_trace_mute_taper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seismic_trace_mute_taper_top
// Self-checking bench for the trace mute and taper block. A stimulus process
// queues traces; a clocked driver pushes them with random gaps and a clocked
// monitor pops results with random stalls. Each result is checked field by
// field against an in-bench model of time clamping, index division,
// sine-squared tapering and dead-trace zeroing, across several register
// settings including the extremes.
// ----------------------------------------------------------------------------
module tb_seismic_trace_mute_taper_top;
  import stmt_pkg::*;

  localparam int TAPER_LEN      = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_SAMPLES = 1700;
  localparam int PRINT_LIMIT    = 60;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       first;
    logic [TIME_W-1:0]          top;
    logic [TIME_W-1:0]          bot;
    logic                       live;
  } trace_sample_t;

  logic                       clk;
  logic                       rst_n               = 1'b0;
  logic                       in_push             = 1'b0;
  logic                       in_full;
  logic signed [SAMPLE_W-1:0] in_sample_value     = '0;
  logic                       in_first_of_trace   = 1'b0;
  logic [TIME_W-1:0]          in_top_mute_time    = '0;
  logic [TIME_W-1:0]          in_bottom_mute_time = '0;
  logic                       in_trace_live       = 1'b0;
  logic                       out_empty;
  logic                       out_pop             = 1'b0;
  logic signed [SAMPLE_W-1:0] out_muted_value;
  logic [TIME_W-1:0]          out_top_mute_out;
  logic [TIME_W-1:0]          out_bottom_mute_out;
  logic                       out_last_of_trace;
  logic                       cfg_valid           = 1'b0;
  logic                       cfg_ready;
  cfg_reg_e                   cfg_index           = CFG_ORIGIN_TIME;
  logic [TIME_W-1:0]          cfg_data            = '0;

  // model copy of the registers and the per-trace state
  longint origin_reg = 0, interval_reg = 4, count_reg = 1000;
  bit     dead_zero_reg = 1'b0;
  int     trace_pos = 0, top_idx = 0, bot_idx = 0;
  bit     trace_is_live = 1'b1;
  int     taper_w [TAPER_LEN];

  trace_sample_t samples_to_send [$];
  out_item_t     muted_due [$];
  trace_sample_t sample_on_bus;
  out_item_t     result_due;

  int send_gap = 0, recv_gap = 0;
  bit send_steady = 1'b0, recv_steady = 1'b0, no_idle = 1'b0;
  int mismatch_count = 0, results_seen = 0, idle_cycles = 0;

  seismic_trace_mute_taper_top #(
    .TAPER_LEN(TAPER_LEN)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_sample_value     (in_sample_value),
    .in_first_of_trace   (in_first_of_trace),
    .in_top_mute_time    (in_top_mute_time),
    .in_bottom_mute_time (in_bottom_mute_time),
    .in_trace_live       (in_trace_live),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_muted_value     (out_muted_value),
    .out_top_mute_out    (out_top_mute_out),
    .out_bottom_mute_out (out_bottom_mute_out),
    .out_last_of_trace   (out_last_of_trace),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sine-squared weights, Q1.16, from a truncated integer Taylor series
  initial begin : taper_table
    longint unsigned x, x2, t, sq, w;
    longint          s;
    for (int k = 0; k < TAPER_LEN; k++) begin
      x  = (64'd3373259427 * 64'(k + 1)) / (2 * TAPER_LEN);
      x2 = (x * x) >> 30;
      t  = x;
      s  = $signed(x);
      for (int m = 1; m <= 7; m++) begin
        t = (t * x2) >> 30;
        t = t / 64'((2 * m) * (2 * m + 1));
        if (m % 2 == 1) begin
          s = s - $signed(t);
        end else begin
          s = s + $signed(t);
        end
      end
      if (s < 0) s = 0;
      sq = $unsigned(s) * $unsigned(s);
      w  = (sq + (64'd1 << 43)) >> 44;
      taper_w[k] = (w > 65536) ? 65536 : int'(w);
    end
  end

  function automatic int taper_scale(int v, int w);
    longint mag;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    mag = (mag * w + 32768) >>> 16;
    return (v < 0) ? -int'(mag) : int'(mag);
  endfunction

  function automatic out_item_t mute_taper_predict(trace_sample_t s);
    out_item_t r;
    longint    n, dt, ot, tmax, top, bot;
    int        v, j;
    n  = (count_reg == 0) ? 1 : count_reg;
    dt = (interval_reg == 0) ? 1 : interval_reg;
    r.top_out = '0;
    r.bot_out = '0;
    if (s.first) begin
      ot   = origin_reg;
      tmax = ot + (n - 1) * dt;
      top  = longint'(s.top);
      bot  = (s.bot == 0) ? tmax : longint'(s.bot);
      if (top < ot) top = ot;
      if (top > tmax) top = tmax;
      if (bot < ot) bot = ot;
      if (bot > tmax) bot = tmax;
      top_idx       = int'((top - ot) / dt);
      bot_idx       = int'((bot - ot) / dt);
      trace_is_live = s.live;
      trace_pos     = 0;
      r.top_out     = top[TIME_W-1:0];
      r.bot_out     = (bot > 65535) ? 16'hFFFF : bot[TIME_W-1:0];
    end
    j = trace_pos;
    v = int'(s.value);
    if (!trace_is_live && dead_zero_reg) begin
      v = 0;
    end else if (j < top_idx || j >= bot_idx) begin
      v = 0;
    end else begin
      if (j - top_idx < TAPER_LEN) v = taper_scale(v, taper_w[j - top_idx]);
      if (bot_idx - 1 - j < TAPER_LEN) v = taper_scale(v, taper_w[bot_idx - 1 - j]);
    end
    r.value = SAMPLE_W'(v);
    r.last  = (j == n - 1);
    if (trace_pos < 65535) trace_pos++;
    return r;
  endfunction

  function automatic int idle_len(bit steady);
    int r;
    if (steady || no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample_value();
    case ($urandom_range(0, 15))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'hFFFFFF;
      3:       return 24'h000001;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_mute_time(longint ot, longint dt, int span);
    longint t;
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return '0;
      default: begin
        t = ot + longint'($urandom_range(0, span)) * dt + longint'($urandom_range(0, dt - 1));
        return (t > 65535) ? 16'hFFFF : 16'(t);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t result %0d: %s got %0d want %0d", $time, results_seen, what, got, want);
    end
  endtask

  task automatic queue_sample(logic [SAMPLE_W-1:0] value, logic first,
                              logic [TIME_W-1:0] top, logic [TIME_W-1:0] bot, logic live);
    trace_sample_t s;
    s.value = value;
    s.first = first;
    s.top   = top;
    s.bot   = bot;
    s.live  = live;
    samples_to_send.push_back(s);
  endtask

  // mute fields of followers are ignored, so fill them with noise
  task automatic queue_followers(int count);
    for (int k = 0; k < count; k++) begin
      queue_sample(random_sample_value(), 1'b0, 16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic queue_trace(int len, logic [TIME_W-1:0] top, logic [TIME_W-1:0] bot,
                             logic live);
    queue_sample(random_sample_value(), 1'b1, top, bot, live);
    queue_followers(len - 1);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk); while (samples_to_send.size() != 0 || in_push || muted_due.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [TIME_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ORIGIN_TIME:       origin_reg    = longint'(data);
      CFG_SAMPLE_INTERVAL:   interval_reg  = longint'(data);
      CFG_SAMPLES_PER_TRACE: count_reg     = longint'(data);
      CFG_ZERO_DEAD_TRACES:  dead_zero_reg = data[0];
      default:               ;
    endcase
  endtask

  task automatic configure(logic [TIME_W-1:0] origin, logic [TIME_W-1:0] interval,
                           logic [TIME_W-1:0] count, logic zero_dead);
    write_reg(CFG_ORIGIN_TIME, origin);
    write_reg(CFG_SAMPLE_INTERVAL, interval);
    write_reg(CFG_SAMPLES_PER_TRACE, count);
    write_reg(CFG_ZERO_DEAD_TRACES, {15'($urandom), zero_dead});
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        muted_due.push_back(mute_taper_predict(sample_on_bus));
      end
      if (!in_push || !in_full) begin
        if (send_gap > 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          sample_on_bus = samples_to_send.pop_front();
          in_sample_value     <= sample_on_bus.value;
          in_first_of_trace   <= sample_on_bus.first;
          in_top_mute_time    <= sample_on_bus.top;
          in_bottom_mute_time <= sample_on_bus.bot;
          in_trace_live       <= sample_on_bus.live;
          in_push             <= 1'b1;
          if ($urandom_range(0, 149) == 0) send_steady = !send_steady;
          send_gap = idle_len(send_steady);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (muted_due.size() == 0) begin
          report_mismatch("result with nothing due, value", out_muted_value, 0);
        end else begin
          result_due = muted_due.pop_front();
          if (out_muted_value !== result_due.value)
            report_mismatch("muted_value", out_muted_value, result_due.value);
          if (out_top_mute_out !== result_due.top_out)
            report_mismatch("top_mute_out", out_top_mute_out, result_due.top_out);
          if (out_bottom_mute_out !== result_due.bot_out)
            report_mismatch("bottom_mute_out", out_bottom_mute_out, result_due.bot_out);
          if (out_last_of_trace !== result_due.last)
            report_mismatch("last_of_trace", out_last_of_trace, result_due.last);
        end
        if ($urandom_range(0, 149) == 0) recv_steady = !recv_steady;
        recv_gap = idle_len(recv_steady);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                made, phase_left, len, n_eff, dt_eff, span;
    logic [TIME_W-1:0] org, ivl, cnt;

    do @(negedge clk); while (!rst_n);

    // reset settings; samples ahead of any trace start must come out zero
    queue_sample(24'h7FFFFF, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_sample(24'h800000, 1'b0, 16'h0000, 16'h0000, 1'b1);
    queue_sample(24'h800000, 1'b1, 16'h0000, 16'h0000, 1'b1);
    queue_sample(24'h7FFFFF, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_sample(24'hFFFFFF, 1'b0, 16'h0000, 16'h0000, 1'b1);
    queue_sample(24'h000001, 1'b0, 16'hAAAA, 16'h5555, 1'b0);
    wait_until_drained();

    // clamping on both sides, dead trace, overlapping tapers, samples past the end
    configure(16'd100, 16'd3, 16'd10, 1'b1);
    queue_trace(2, 16'd50, 16'hFFFF, 1'b0);
    queue_trace(12, 16'd106, 16'd120, 1'b1);
    queue_trace(2, 16'd125, 16'd110, 1'b1);
    wait_until_drained();

    // zero count and zero interval
    configure(16'hFFFF, 16'd0, 16'd0, 1'b0);
    queue_trace(2, 16'd0, 16'd0, 1'b1);
    wait_until_drained();

    // largest settings; trace end beyond 16 bits
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    no_idle = 1'b1;
    queue_trace(40, 16'hFFFF, 16'd0, 1'b1);
    wait_until_drained();
    no_idle = 1'b0;

    made       = 0;
    phase_left = 0;
    while (made < RANDOM_SAMPLES) begin
      if (phase_left <= 0) begin
        wait_until_drained();
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0, 1:    org = '0;
            2:       org = 16'hFFFF;
            3, 4:    org = 16'($urandom);
            default: org = 16'($urandom_range(0, 2000));
          endcase
          case ($urandom_range(0, 19))
            0:          ivl = '0;
            1, 2:       ivl = 16'hFFFF;
            3, 4:       ivl = 16'd1;
            5, 6, 7:    ivl = 16'($urandom);
            8, 9, 10:   ivl = 16'($urandom_range(5, 300));
            default:    ivl = 16'($urandom_range(1, 4));
          endcase
          case ($urandom_range(0, 19))
            0:          cnt = '0;
            1:          cnt = 16'd1;
            2:          cnt = 16'hFFFF;
            3:          cnt = 16'($urandom_range(161, 5000));
            4, 5, 6, 7: cnt = 16'($urandom_range(65, 160));
            default:    cnt = 16'($urandom_range(2, 64));
          endcase
          configure(org, ivl, cnt, 1'($urandom));
        end
        // resume the open trace under the new settings
        if ($urandom_range(0, 1) == 1) begin
          len = $urandom_range(1, 6);
          queue_followers(len);
          made += len;
        end
        phase_left = $urandom_range(100, 350);
      end
      n_eff  = (count_reg == 0) ? 1 : int'(count_reg);
      dt_eff = (interval_reg == 0) ? 1 : int'(interval_reg);
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, (n_eff < 115) ? n_eff + 5 : 120);
        default: len = n_eff - 2 + int'($urandom_range(0, 4));
      endcase
      if (len < 1) len = 1;
      if (len > 300) len = 300;
      span = (n_eff < len + 20) ? n_eff + 2 : len + 20;
      queue_trace(len, pick_mute_time(origin_reg, dt_eff, span),
                  pick_mute_time(origin_reg, dt_eff, span), $urandom_range(0, 7) != 0);
      made       += len;
      phase_left -= len;
    end

    wait_until_drained();
    repeat (60) @(negedge clk);
    if (muted_due.size() != 0) report_mismatch("results never delivered", 0, muted_due.size());
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
